@@ src/bmsd_pkg.sv @@
// Shared types, sizes and helpers for the button matrix scanner.
// No dependencies; used by every module of the block.
`default_nettype none

package bmsd_pkg;

	localparam int NUM_MODULES       = 5;
	localparam int NUM_ROWS          = 8;
	localparam int NUM_INPUT_MODULES = 5;
	localparam int NUM_ENTRIES       = NUM_MODULES * NUM_ROWS;
	localparam int IDX_W             = $clog2(NUM_ENTRIES);
	localparam int CNT_W             = $clog2(NUM_ENTRIES + 1);
	localparam int ROW_W             = $clog2(NUM_ROWS);
	localparam int MOD_W             = 3;
	localparam int PIN_W             = 9;

	localparam logic [7:0] RELOAD_RESET = 8'd10;
	localparam logic [7:0] ALL_RELEASED = 8'hff;

	localparam logic CMD_SCAN = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] din_module0;
		logic [7:0] din_module1;
		logic [7:0] din_module2;
		logic [7:0] din_module3;
		logic [7:0] din_module4;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0] next_row;
		logic             event_valid;
		logic [PIN_W-1:0] event_pin;
		logic             event_level;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic walk;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_needed;
		logic hit;
		logic walk_end;
	} dp_status_t;

	function automatic logic [7:0] sample_of(input in_item_t item, input logic [MOD_W-1:0] m);
		logic [7:0] s;
		case (m)
			3'd0: s = item.din_module0;
			3'd1: s = item.din_module1;
			3'd2: s = item.din_module2;
			3'd3: s = item.din_module3;
			3'd4: s = item.din_module4;
			default: s = ALL_RELEASED;
		endcase
		return s;
	endfunction

	function automatic logic [2:0] lowest_bit(input logic [7:0] v);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) idx = 3'(i);
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

@@ src/bmsd_ctrl.sv @@
// Controller state machine: accepts an item, runs the entry walk when one is needed, strobes the result.
// Depends on bmsd_pkg.
`default_nettype none

module bmsd_ctrl
	import bmsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  dp_status_t      status,
	output dp_cmd_t         cmd,
	output logic            busy,
	output logic            done
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = status.walk_needed ? ST_WALK : ST_DONE;
			end
			ST_WALK: begin
				if (status.walk_end) state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_WALK: begin
				cmd.walk   = 1'b1;
				cmd.commit = status.hit;
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/bmsd_dp.sv @@
// Datapath: row and debounce counters, level/pending memories, walk counter, result regs.
// Depends on bmsd_pkg; driven by bmsd_ctrl.
`default_nettype none

module bmsd_dp
	import bmsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  in_item_t        req,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data,
	input  dp_cmd_t         cmd,
	output dp_status_t      status,
	output out_item_t       result
);

	logic [7:0]       reload_q;
	logic [7:0]       cnt_q;
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] cur_row_q;
	logic             poll_q;
	in_item_t         item_q;
	logic [CNT_W-1:0] w_q;
	logic [NUM_ENTRIES-1:0] written_q;

	logic [7:0] levels_mem [NUM_ENTRIES];
	logic [7:0] pend_mem   [NUM_ENTRIES];

	logic             rd_vld_s1;
	logic             last_s1;
	logic             wr_s1;
	logic [IDX_W-1:0] addr_s1;
	logic [MOD_W-1:0] mod_s1;
	logic [7:0]       lvl_s1;
	logic [7:0]       pend_s1;

	logic             ev_valid_q;
	logic [PIN_W-1:0] ev_pin_q;
	logic             ev_level_q;

	logic [CNT_W-1:0] w_limit;
	logic             issue;
	logic [IDX_W-1:0] rd_addr;
	logic [7:0]       lvl_eff;
	logic [7:0]       pend_eff;
	logic [7:0]       sample;
	logic [7:0]       diff;
	logic             hit_raw;
	logic [2:0]       bit_idx;

	always_comb begin
		w_limit  = poll_q ? CNT_W'(NUM_ENTRIES - 1) : CNT_W'(NUM_MODULES - 1);
		issue    = cmd.walk && (w_q <= w_limit);
		rd_addr  = poll_q ? IDX_W'(w_q) : IDX_W'({w_q, cur_row_q});
		lvl_eff  = wr_s1 ? lvl_s1 : ALL_RELEASED;
		pend_eff = wr_s1 ? pend_s1 : 8'd0;
		sample   = sample_of(item_q, mod_s1);
		diff     = sample ^ lvl_eff;
		hit_raw  = poll_q ? (pend_eff != 8'd0) : (diff != 8'd0);
		bit_idx  = lowest_bit(pend_eff);
	end

	assign status.walk_needed = (req.command == CMD_POLL) || (cnt_q <= 8'd1);
	assign status.hit         = rd_vld_s1 && hit_raw;
	// a reload of zero leaves debouncing off, so later modules still compare
	assign status.walk_end    = rd_vld_s1 &&
		(last_s1 || (hit_raw && (poll_q || (reload_q != 8'd0))));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q  <= RELOAD_RESET;
			cnt_q     <= 8'd0;
			row_q     <= '0;
			poll_q    <= 1'b0;
			w_q       <= '0;
			written_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cfg_we) reload_q <= cfg_data;
			if (cmd.accept) begin
				poll_q <= req.command;
				w_q    <= '0;
				if (req.command == CMD_SCAN) begin
					row_q <= row_q + ROW_W'(1);
					if (cnt_q != 8'd0) cnt_q <= cnt_q - 8'd1;
				end
			end else if (issue) begin
				w_q <= w_q + CNT_W'(1);
			end
			if (cmd.commit) begin
				written_q[addr_s1] <= 1'b1;
				if (!poll_q) cnt_q <= reload_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q     <= req;
			cur_row_q  <= row_q;
			ev_valid_q <= 1'b0;
			ev_pin_q   <= '0;
			ev_level_q <= 1'b0;
		end
		if (cmd.commit && poll_q) begin
			ev_valid_q <= 1'b1;
			ev_pin_q   <= PIN_W'({addr_s1, bit_idx});
			ev_level_q <= lvl_eff[bit_idx];
		end
		last_s1 <= (w_q == w_limit);
		wr_s1   <= written_q[rd_addr];
		addr_s1 <= rd_addr;
		mod_s1  <= w_q[MOD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (poll_q) begin
				pend_mem[addr_s1] <= pend_eff & ~(8'd1 << bit_idx);
			end else begin
				pend_mem[addr_s1]   <= pend_eff | diff;
				levels_mem[addr_s1] <= sample;
			end
		end
		lvl_s1  <= levels_mem[rd_addr];
		pend_s1 <= pend_mem[rd_addr];
	end

	assign result.next_row    = row_q;
	assign result.event_valid = ev_valid_q;
	assign result.event_pin   = ev_pin_q;
	assign result.event_level = ev_level_q;

	a_commit_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> rd_vld_s1)
		else $error("commit without read data");

	a_count_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && req.command == CMD_SCAN && cnt_q > 8'd1)
		|=> cnt_q == 8'($past(cnt_q) - 8'd1))
		else $error("debounce count not decremented");

	a_poll_keeps_row: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && req.command == CMD_POLL) |=> row_q == $past(row_q))
		else $error("poll moved row counter");

	a_scan_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !poll_q) |=> cnt_q == $past(reload_q))
		else $error("debounce count not reloaded");

endmodule

`default_nettype wire

@@ src/button_matrix_scan_debounce.sv @@
// Top level of the button matrix scanner with shared debounce counter.
// Depends on bmsd_pkg, bmsd_ctrl and bmsd_dp.
`default_nettype none

// Raise start with an item while busy is low. A scan item skips the walk when
// the debounce counter is still running; otherwise it walks the modules, one
// module row read per cycle from the level memory. A poll walks up to the
// NUM_MODULES*8 stored rows one per cycle through the pending memory. Exactly
// one result per item is flagged by done, which is high for a single cycle;
// it cannot be held off, so the receiver must take it then. The user must
// write debounce_reload through cfg_we/cfg_data only while the block is idle;
// the block itself does not enforce this. No clearing pass is needed after
// reset.
module button_matrix_scan_debounce
	import bmsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  in_item_t        req,
	output logic            done,
	output out_item_t       result,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	bmsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bmsd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.result   (result)
	);

endmodule

`default_nettype wire
